// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/dthp_pkg.sv =====
package dthp_pkg;

	localparam int MAX_LENGTH_OCTETS = 4;
	localparam int TAG_WIDTH = 32;
	localparam int LOCT_W = $clog2(MAX_LENGTH_OCTETS + 1);

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [4:0] LONG_TAG_MARK = 5'h1F;
	localparam logic [3:0] HDR_MAX = 4'd15;
	localparam logic [31:0] LEN_SHIFT_MAX = 32'h00FF_FFFF;

	typedef enum logic [2:0] {
		PH_IDENT,
		PH_TAG_LONG,
		PH_LEN_FIRST,
		PH_LEN_LONG,
		PH_CONTENT
	} phase_t;

	typedef enum logic {
		KIND_HEADER,
		KIND_CONTENT
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_TAG_WIDE,
		ERR_LEN_OCTETS
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  tag_class;
		logic        constructed;
		logic [31:0] tag_number;
		logic [31:0] content_length;
		logic [3:0]  header_bytes;
		logic [7:0]  content_byte;
		logic        item_end;
		err_t        error_code;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/dthp_front.sv =====
`include "assert_macros.svh"

module dthp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_accept,
	input  logic [7:0]       data_byte,
	input  logic             cfg_we,
	input  logic             cfg_pass,
	output logic             push,
	output dthp_pkg::res_t   push_data
);

	dthp_pkg::phase_t                phase_q, phase_d;
	logic [1:0]                      class_q, class_d;
	logic                            cons_q, cons_d;
	logic [dthp_pkg::TAG_WIDTH-1:0]  tag_q, tag_d;
	logic [dthp_pkg::TAG_WIDTH-1:0]  tag_shift;
	logic                            tag_top;
	logic [31:0]                     len_q, len_d;
	logic [dthp_pkg::LOCT_W-1:0]     loct_q, loct_d;
	logic [3:0]                      hcnt_q, hcnt_d, hcnt_inc;
	logic [31:0]                     cleft_q, cleft_d;
	logic                            tag_err_q, tag_err_d;
	logic                            pass_q;
	logic                            hdr_emit;

	assign tag_shift = (tag_q << 7) | dthp_pkg::TAG_WIDTH'(data_byte[6:0]);
	assign tag_top   = (tag_q >> (dthp_pkg::TAG_WIDTH - 7)) != '0;
	assign hcnt_inc  = (hcnt_q < dthp_pkg::HDR_MAX) ? hcnt_q + 4'd1 : hcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= dthp_pkg::PH_IDENT;
			class_q   <= '0;
			cons_q    <= 1'b0;
			tag_q     <= '0;
			len_q     <= '0;
			loct_q    <= '0;
			hcnt_q    <= '0;
			cleft_q   <= '0;
			tag_err_q <= 1'b0;
			pass_q    <= 1'b1;
		end else begin
			phase_q   <= phase_d;
			class_q   <= class_d;
			cons_q    <= cons_d;
			tag_q     <= tag_d;
			len_q     <= len_d;
			loct_q    <= loct_d;
			hcnt_q    <= hcnt_d;
			cleft_q   <= cleft_d;
			tag_err_q <= tag_err_d;
			if (cfg_we) begin
				pass_q <= cfg_pass;
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		class_d   = class_q;
		cons_d    = cons_q;
		tag_d     = tag_q;
		len_d     = len_q;
		loct_d    = loct_q;
		hcnt_d    = hcnt_q;
		cleft_d   = cleft_q;
		tag_err_d = tag_err_q;
		hdr_emit  = 1'b0;
		push      = 1'b0;

		push_data.kind         = dthp_pkg::KIND_HEADER;
		push_data.content_byte = 8'd0;
		push_data.item_end     = 1'b0;
		push_data.error_code   = tag_err_q ? dthp_pkg::ERR_TAG_WIDE : dthp_pkg::ERR_NONE;

		if (in_accept) begin
			case (phase_q)
				dthp_pkg::PH_IDENT: begin
					class_d   = data_byte[7:6];
					cons_d    = data_byte[5];
					len_d     = '0;
					tag_err_d = 1'b0;
					hcnt_d    = 4'd1;
					if (data_byte[4:0] != dthp_pkg::LONG_TAG_MARK) begin
						tag_d   = dthp_pkg::TAG_WIDTH'(data_byte[4:0]);
						phase_d = dthp_pkg::PH_LEN_FIRST;
					end else begin
						tag_d   = '0;
						phase_d = dthp_pkg::PH_TAG_LONG;
					end
				end
				dthp_pkg::PH_TAG_LONG: begin
					hcnt_d = hcnt_inc;
					if (tag_top || tag_err_q) begin
						tag_err_d = 1'b1;
						tag_d     = '1;
					end else begin
						tag_d = tag_shift;
					end
					if (!data_byte[7]) begin
						phase_d = dthp_pkg::PH_LEN_FIRST;
					end
				end
				dthp_pkg::PH_LEN_FIRST: begin
					hcnt_d = hcnt_inc;
					len_d  = '0;
					if (!data_byte[7]) begin
						len_d    = 32'(data_byte[6:0]);
						hdr_emit = 1'b1;
					end else if (data_byte[6:0] == 7'd0) begin
						hdr_emit = 1'b1;
					end else if (data_byte[6:0] > 7'(dthp_pkg::MAX_LENGTH_OCTETS)) begin
						push                 = 1'b1;
						push_data.item_end   = 1'b1;
						push_data.error_code = dthp_pkg::ERR_LEN_OCTETS;
						phase_d              = dthp_pkg::PH_IDENT;
					end else begin
						loct_d  = dthp_pkg::LOCT_W'(data_byte[6:0]);
						phase_d = dthp_pkg::PH_LEN_LONG;
					end
				end
				dthp_pkg::PH_LEN_LONG: begin
					hcnt_d = hcnt_inc;
					len_d  = (len_q > dthp_pkg::LEN_SHIFT_MAX) ? '1 : {len_q[23:0], data_byte};
					if (loct_q != '0) begin
						loct_d = loct_q - 1'b1;
					end
					if (loct_d == '0) begin
						hdr_emit = 1'b1;
					end
				end
				dthp_pkg::PH_CONTENT: begin
					if (cleft_q != '0) begin
						cleft_d = cleft_q - 32'd1;
					end
					push_data.item_end = (cleft_d == '0);
					if (cleft_d == '0) begin
						phase_d = dthp_pkg::PH_IDENT;
					end
					if (pass_q) begin
						push                   = 1'b1;
						push_data.kind         = dthp_pkg::KIND_CONTENT;
						push_data.content_byte = data_byte;
					end
				end
				default: begin
					phase_d = dthp_pkg::PH_IDENT;
				end
			endcase

			if (hdr_emit) begin
				push               = 1'b1;
				push_data.item_end = (len_d == '0);
				if (len_d == '0) begin
					phase_d = dthp_pkg::PH_IDENT;
				end else begin
					cleft_d = len_d;
					phase_d = dthp_pkg::PH_CONTENT;
				end
			end
		end

		push_data.tag_class      = class_d;
		push_data.constructed    = cons_d;
		push_data.tag_number     = 32'(tag_d);
		push_data.content_length = len_d;
		push_data.header_bytes   = hcnt_d;
	end

	`ASSERT_AT(a_loct_live, clk, arst_n, (phase_q == dthp_pkg::PH_LEN_LONG) |-> (loct_q != '0))
	`ASSERT_AT(a_content_live, clk, arst_n, (phase_q == dthp_pkg::PH_CONTENT) |-> (cleft_q != '0))
	`ASSERT_AT(a_tag_saturated, clk, arst_n, tag_err_q |-> (tag_q == '1))

endmodule

// ===== rtl/dthp_queue.sv =====
`include "assert_macros.svh"

module dthp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dthp_pkg::res_t   wdata,
	input  logic             pop,
	output dthp_pkg::res_t   rdata,
	output dthp_pkg::qstat_t stat
);

	dthp_pkg::res_t              q_mem [dthp_pkg::Q_DEPTH];
	logic [dthp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [dthp_pkg::QCNT_W-1:0] count_q;

	function automatic logic [dthp_pkg::QPTR_W-1:0] ptr_next(
		input logic [dthp_pkg::QPTR_W-1:0] ptr
	);
		return (ptr == dthp_pkg::QPTR_W'(dthp_pkg::Q_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign stat.full  = (count_q == dthp_pkg::QCNT_W'(dthp_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && stat.full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && stat.empty)
	`ASSERT_AT(a_empty_ptrs, clk, arst_n, stat.empty |-> (wr_ptr_q == rd_ptr_q))

endmodule

// ===== rtl/dthp_back.sv =====
module dthp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dthp_pkg::qstat_t stat,
	input  dthp_pkg::res_t   rdata,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output dthp_pkg::res_t   out_res
);

	logic           valid_q;
	dthp_pkg::res_t res_q;

	assign pop       = !stat.empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= rdata;
		end
	end

endmodule

// ===== rtl/der_tlv_header_parser.sv =====
// DER TLV header parser.
// Input channel: in_valid / in_stall with data_byte, one byte of the DER
// stream per item. Output channel: out_valid / out_stall with one result per
// item: a header result when the length octets are complete or too many, and
// with pass_content set, one per content byte, the last one with item_end.
// Configuration: cfg_valid / cfg_ready writes pass_content; cfg_ready is
// always high. Write it only while the parser is idle.
// Throughput: one byte per cycle while in_stall is low. The parser state
// machine classifies a byte in the cycle it is accepted and pushes its result
// into a two-entry queue; the output register drains that queue one result
// per cycle while out_stall is low. A result is written into the queue when
// its byte is accepted and is loaded from there into the output register,
// which drives out_valid, once that register is free.
// Reset: pass_content returns to 1, the parser expects an identifier byte,
// the queue and output register are empty.
// Receiver stall: the output register holds; the queue fills, and once it
// holds two results in_stall rises until the receiver takes one.
module der_tlv_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        pass_content,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [1:0]  tag_class,
	output logic        constructed,
	output logic [31:0] tag_number,
	output logic [31:0] content_length,
	output logic [3:0]  header_bytes,
	output logic [7:0]  content_byte,
	output logic        item_end,
	output logic [1:0]  error_code
);

	logic             in_accept;
	logic             push;
	logic             pop;
	dthp_pkg::res_t   push_data;
	dthp_pkg::res_t   q_rdata;
	dthp_pkg::res_t   out_res;
	dthp_pkg::qstat_t q_stat;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_stat.full;
	assign in_accept = in_valid && !in_stall;

	dthp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.data_byte (data_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_pass  (pass_content),
		.push      (push),
		.push_data (push_data)
	);

	dthp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	dthp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (q_stat),
		.rdata     (q_rdata),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign result_kind    = out_res.kind;
	assign tag_class      = out_res.tag_class;
	assign constructed    = out_res.constructed;
	assign tag_number     = out_res.tag_number;
	assign content_length = out_res.content_length;
	assign header_bytes   = out_res.header_bytes;
	assign content_byte   = out_res.content_byte;
	assign item_end       = out_res.item_end;
	assign error_code     = out_res.error_code;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int SETTLE_CYCLES = 8;

	class tlv_tracker;
		dthp_pkg::res_t due_results[$];
		dthp_pkg::phase_t phase;
		logic [1:0] cls;
		logic cons;
		logic [31:0] tag;
		logic [31:0] len;
		int unsigned octets_left;
		logic [3:0] hdr_cnt;
		logic [31:0] left;
		bit tag_err;
		bit pass_en;
		int mismatches;

		function new();
			phase = dthp_pkg::PH_IDENT;
			cls = '0;
			cons = 1'b0;
			tag = '0;
			len = '0;
			octets_left = 0;
			hdr_cnt = '0;
			left = '0;
			tag_err = 1'b0;
			pass_en = 1'b1;
			mismatches = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void bump_count();
			if (hdr_cnt != dthp_pkg::HDR_MAX)
				hdr_cnt++;
		endfunction

		function void push_result(dthp_pkg::kind_t k, dthp_pkg::err_t e, logic [7:0] d,
			logic fin);
			dthp_pkg::res_t r;
			r.kind = k;
			r.tag_class = cls;
			r.constructed = cons;
			r.tag_number = tag;
			r.content_length = len;
			r.header_bytes = hdr_cnt;
			r.content_byte = d;
			r.item_end = fin;
			r.error_code = e;
			due_results.insert(due_results.size(), r);
		endfunction

		function void header_done();
			push_result(dthp_pkg::KIND_HEADER,
				tag_err ? dthp_pkg::ERR_TAG_WIDE : dthp_pkg::ERR_NONE, 8'h00, len == 0);
			if (len == 0) begin
				phase = dthp_pkg::PH_IDENT;
			end else begin
				left = len;
				phase = dthp_pkg::PH_CONTENT;
			end
		endfunction

		function void parse_byte(logic [7:0] b);
			logic fin;
			case (phase)
				dthp_pkg::PH_IDENT: begin
					cls = b[7:6];
					cons = b[5];
					len = '0;
					tag_err = 1'b0;
					hdr_cnt = 4'd1;
					if (b[4:0] != dthp_pkg::LONG_TAG_MARK) begin
						tag = {27'd0, b[4:0]};
						phase = dthp_pkg::PH_LEN_FIRST;
					end else begin
						tag = '0;
						phase = dthp_pkg::PH_TAG_LONG;
					end
				end
				dthp_pkg::PH_TAG_LONG: begin
					bump_count();
					if ((tag >> (dthp_pkg::TAG_WIDTH - 7)) != 0 || tag_err) begin
						tag_err = 1'b1;
						tag = '1;
					end else begin
						tag = {tag[24:0], b[6:0]};
					end
					if (!b[7])
						phase = dthp_pkg::PH_LEN_FIRST;
				end
				dthp_pkg::PH_LEN_FIRST: begin
					bump_count();
					if (!b[7]) begin
						len = {25'd0, b[6:0]};
						header_done();
					end else if (b[6:0] == 0) begin
						len = '0;
						header_done();
					end else if (b[6:0] > dthp_pkg::MAX_LENGTH_OCTETS) begin
						len = '0;
						push_result(dthp_pkg::KIND_HEADER, dthp_pkg::ERR_LEN_OCTETS, 8'h00, 1'b1);
						phase = dthp_pkg::PH_IDENT;
					end else begin
						len = '0;
						octets_left = b[6:0];
						phase = dthp_pkg::PH_LEN_LONG;
					end
				end
				dthp_pkg::PH_LEN_LONG: begin
					bump_count();
					if (len > dthp_pkg::LEN_SHIFT_MAX)
						len = '1;
					else
						len = {len[23:0], b};
					if (octets_left > 0)
						octets_left--;
					if (octets_left == 0)
						header_done();
				end
				dthp_pkg::PH_CONTENT: begin
					if (left > 0)
						left--;
					fin = (left == 0);
					if (fin)
						phase = dthp_pkg::PH_IDENT;
					if (pass_en)
						push_result(dthp_pkg::KIND_CONTENT,
							tag_err ? dthp_pkg::ERR_TAG_WIDE : dthp_pkg::ERR_NONE, b, fin);
				end
				default: phase = dthp_pkg::PH_IDENT;
			endcase
		endfunction

		function string show(dthp_pkg::res_t r);
			return $sformatf(
				"kind=%0d cls=%0d cons=%0d tag=%h len=%h hdr=%0d byte=%h end=%0d err=%0d",
				r.kind, r.tag_class, r.constructed, r.tag_number, r.content_length,
				r.header_bytes, r.content_byte, r.item_end, r.error_code);
		endfunction

		function void check_result(dthp_pkg::res_t got);
			dthp_pkg::res_t want;
			bit bad;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", show(got));
				return;
			end
			want = due_results.pop_front();
			bad = (got.kind !== want.kind) || (got.tag_class !== want.tag_class) ||
				(got.constructed !== want.constructed) ||
				(got.tag_number !== want.tag_number) ||
				(got.content_length !== want.content_length) ||
				(got.header_bytes !== want.header_bytes) ||
				(got.content_byte !== want.content_byte) ||
				(got.item_end !== want.item_end) || (got.error_code !== want.error_code);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch expected: %s", show(want));
					$display("         actual:   %s", show(got));
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        pass_content;
	logic        out_valid;
	logic        out_stall;
	logic        result_kind;
	logic [1:0]  tag_class;
	logic        constructed;
	logic [31:0] tag_number;
	logic [31:0] content_length;
	logic [3:0]  header_bytes;
	logic [7:0]  content_byte;
	logic        item_end;
	logic [1:0]  error_code;

	tlv_tracker sb = new();
	logic [7:0] stream_q[$];
	int burst_left = 0;
	int stall_mode = 0;
	int stall_span = 0;

	der_tlv_header_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.pass_content   (pass_content),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.tag_class      (tag_class),
		.constructed    (constructed),
		.tag_number     (tag_number),
		.content_length (content_length),
		.header_bytes   (header_bytes),
		.content_byte   (content_byte),
		.item_end       (item_end),
		.error_code     (error_code)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			sb.pass_en = pass_content;
		if (arst_n && in_valid && !in_stall)
			sb.parse_byte(data_byte);
	end

	always @(posedge clk) begin : result_mon
		dthp_pkg::res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = dthp_pkg::kind_t'(result_kind);
			got.tag_class = tag_class;
			got.constructed = constructed;
			got.tag_number = tag_number;
			got.content_length = content_length;
			got.header_bytes = header_bytes;
			got.content_byte = content_byte;
			got.item_end = item_end;
			got.error_code = dthp_pkg::err_t'(error_code);
			sb.check_result(got);
		end
	end

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(20, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_span[2];
		endcase
	end

	function automatic void put_byte(logic [7:0] b);
		stream_q.insert(stream_q.size(), b);
	endfunction

	function automatic void add_item(logic [1:0] cls, bit cons, logic [63:0] tag, bit long_tag,
		int pad, logic [31:0] len, int len_octets, int body);
		logic [6:0] groups[$];
		logic [63:0] t;
		if (!long_tag) begin
			put_byte({cls, cons, tag[4:0]});
		end else begin
			put_byte({cls, cons, dthp_pkg::LONG_TAG_MARK});
			t = tag;
			do begin
				groups.push_front(t[6:0]);
				t = t >> 7;
			end while (t != 0);
			repeat (pad) put_byte(8'h80);
			for (int i = 0; i < groups.size(); i++)
				put_byte({i != groups.size() - 1, groups[i]});
		end
		if (len_octets == 0) begin
			put_byte({1'b0, len[6:0]});
		end else begin
			put_byte(8'h80 | 8'(len_octets));
			for (int i = len_octets - 1; i >= 0; i--)
				put_byte(len[8 * i +: 8]);
		end
		repeat (body) put_byte(8'($urandom));
	endfunction

	function automatic void add_random_item();
		int sel;
		int bits;
		int oct;
		int len;
		bit long_tag;
		logic [63:0] tag;
		logic [1:0] cls;
		bit cons;
		sel = $urandom_range(0, 99);
		cls = 2'($urandom);
		cons = 1'($urandom);
		long_tag = ($urandom_range(0, 9) < 3);
		if (long_tag) begin
			bits = $urandom_range(1, 36);
			tag = {$urandom, $urandom};
			tag = tag >> (64 - bits);
		end else begin
			tag = $urandom_range(0, 30);
		end
		if (sel < 80) begin
			case ($urandom_range(0, 9))
				0: begin
					len = 0;
					oct = 0;
				end
				1, 2, 3, 4, 5: begin
					len = $urandom_range(1, 20);
					oct = 0;
				end
				6, 7: begin
					len = $urandom_range(21, 127);
					oct = 0;
				end
				default: begin
					oct = $urandom_range(1, 4);
					len = $urandom_range(0, (oct == 1) ? 255 : 600);
				end
			endcase
			add_item(cls, cons, tag, long_tag,
				($urandom_range(0, 19) == 0) ? $urandom_range(1, 12) : 0, len, oct, len);
		end else begin
			add_item(cls, cons, tag, long_tag, 0, 0, 0, 0);
			void'(stream_q.pop_back());
			if (sel < 90)
				put_byte(8'h80);
			else
				put_byte(8'($urandom_range(8'h80 + dthp_pkg::MAX_LENGTH_OCTETS + 1, 8'hFF)));
		end
	endfunction

	task automatic send_stream();
		logic [7:0] b;
		int gap_len;
		while (stream_q.size() > 0) begin
			b = stream_q.pop_front();
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
				gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap_len > 0) begin
					in_valid <= 1'b0;
					repeat (gap_len) @(negedge clk);
				end
			end
			burst_left--;
			in_valid <= 1'b1;
			data_byte <= b;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b0;
	endtask

	task automatic write_pass(bit v);
		cfg_valid <= 1'b1;
		pass_content <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		cfg_valid = 1'b0;
		pass_content = 1'b1;
		out_stall = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_item(2'd0, 1'b0, 64'd2, 1'b0, 0, 32'd1, 0, 1);
		add_item(2'd3, 1'b1, 64'd30, 1'b0, 0, 32'd0, 0, 0);
		put_byte(8'h30);
		put_byte(8'h80);
		add_item(2'd1, 1'b0, 64'd31, 1'b1, 0, 32'd3, 0, 3);
		add_item(2'd2, 1'b1, 64'hFFFF_FFFF, 1'b1, 0, 32'd2, 0, 2);
		add_item(2'd3, 1'b0, 64'h1_0000_0000, 1'b1, 0, 32'd1, 0, 1);
		add_item(2'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, 32'd127, 0, 127);
		add_item(2'd1, 1'b1, 64'd5, 1'b1, 13, 32'd3, 4, 3);
		add_item(2'd2, 1'b0, 64'd7, 1'b0, 0, 32'd0, 1, 0);
		add_item(2'd0, 1'b0, 64'd4, 1'b0, 0, 32'd300, 2, 300);
		add_item(2'd3, 1'b1, 64'd200, 1'b1, 0, 32'd256, 3, 256);
		put_byte(8'h04);
		put_byte(8'h85);
		put_byte(8'hA1);
		put_byte(8'hFF);
		add_item(2'd2, 1'b0, 64'h7F_FFFF_FFFF, 1'b1, 0, 32'd0, 0, 0);
		void'(stream_q.pop_back());
		put_byte(8'h86);
		add_item(2'd2, 1'b0, 64'd9, 1'b0, 0, 32'd2, 4, 2);
		send_stream();
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_pass(p[0]);
			while (stream_q.size() < 120)
				add_random_item();
			send_stream();
			wait_idle();
		end

		write_pass(1'b1);
		add_item(2'd3, 1'b1, 64'hFFFF_FFFF, 1'b1, 0, 32'hFFFF_FFFF, 4, 5);
		send_stream();
		wait_idle();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#10ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dthp_pkg.sv
rtl/dthp_front.sv
rtl/dthp_queue.sv
rtl/dthp_back.sv
rtl/der_tlv_header_parser.sv
verif/tb.sv
